// ----- rtl/core/kts_pkg.sv -----
`default_nettype none

package kts_pkg;

   localparam int KEY_W               = 32;
   localparam int TAG_W               = 32;
   localparam int ENTRY_W             = KEY_W + TAG_W;
   localparam int DEFAULT_MAX_ENTRIES = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POP,
      ST_POP_WAIT,
      ST_PIV_RD,
      ST_PIV_WR_LO,
      ST_PIV_WR_MID,
      ST_SCAN_A,
      ST_SCAN_A_CHK,
      ST_SCAN_B,
      ST_SCAN_B_CHK,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_FIN_LO,
      ST_FIN_B,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/core/kts_ram.sv -----
`default_nettype none

module kts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- rtl/core/key_tag_quicksort.sv -----
`default_nettype none
// Load: one (key, tag) transfer per cycle while busy is low; busy stays low until last.
// Sort: in place in one entry RAM (one write, one registered read port); each compare
//   step is a read then a check, each swap is two writes, and each range adds pop, pivot and finish states.
// Output: N strobes on consecutive cycles; rsp_final_res marks the last; the receiver
//   cannot stall. Synchronous active-high reset clears the FSM, fill count, stack pointer and strobes.
module key_tag_quicksort #(
   parameter int MAX_ENTRIES = kts_pkg::DEFAULT_MAX_ENTRIES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire logic signed [kts_pkg::KEY_W-1:0] req_key,
   input  wire logic signed [kts_pkg::TAG_W-1:0] req_tag,
   input  wire logic                            req_last,
   output      logic                            rsp_valid,
   output      logic signed [kts_pkg::KEY_W-1:0] rsp_sorted_key,
   output      logic signed [kts_pkg::TAG_W-1:0] rsp_sorted_tag,
   output      logic                            rsp_final_res
);
   import kts_pkg::*;

   localparam int IDXW = $clog2(MAX_ENTRIES);
   localparam int CNTW = IDXW + 1;
   localparam int STKW = 2 * IDXW;

   state_type state_ff, state_in;

   // sort bookkeeping
   logic [CNTW-1:0]    fill_ff, fill_in;
   logic [CNTW-1:0]    sp_ff, sp_in;
   logic [CNTW-1:0]    k_ff, k_in;
   logic [IDXW-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [CNTW-1:0]    a_ff, a_in;
   logic [IDXW-1:0]    b_ff, b_in;
   logic [ENTRY_W-1:0] tmp_ff, tmp_in, piv_ff, piv_in;
   logic [ENTRY_W-1:0] dat_a_ff, dat_a_in, dat_b_ff, dat_b_in;
   logic               pend_ff, pend_in, fin_ff, fin_in;

   // memory ports
   logic               ent_we;
   logic [IDXW-1:0]    ent_waddr, ent_raddr;
   logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
   logic               stk_we;
   logic [IDXW-1:0]    stk_waddr, stk_raddr;
   logic [STKW-1:0]    stk_wdata, stk_rdata;

   logic               accept;
   logic               has_room;
   logic [CNTW-1:0]    n_load;
   logic [CNTW-1:0]    mid_sum;
   logic [IDXW-1:0]    mid;
   logic signed [KEY_W-1:0] rd_key, piv_key;
   logic               push_right, push_left;

   kts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // pending ranges: at most MAX_ENTRIES/2 live at once
   kts_ram #(.WIDTH(STKW), .DEPTH(MAX_ENTRIES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign has_room = (fill_ff < CNTW'(MAX_ENTRIES));
   assign n_load   = has_room ? fill_ff + 1'b1 : fill_ff;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = mid_sum[CNTW-1:1];
   assign rd_key   = ent_rdata[ENTRY_W-1 -: KEY_W];
   assign piv_key  = piv_ff[ENTRY_W-1 -: KEY_W];
   // push only ranges of two or more entries
   assign push_right = ({1'b0, b_ff} + 1'b1) < {1'b0, hi_ff};
   assign push_left  = ({1'b0, lo_ff} + 1'b1) < {1'b0, b_ff};

   // result strobe straight off the registered RAM read
   assign rsp_valid      = pend_ff;
   assign rsp_final_res  = fin_ff;
   assign rsp_sorted_key = ent_rdata[ENTRY_W-1 -: KEY_W];
   assign rsp_sorted_tag = ent_rdata[TAG_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last) begin
               state_in = (n_load > CNTW'(1)) ? ST_POP : ST_OUT;
            end
         end
         ST_POP:        state_in = ST_POP_WAIT;
         ST_POP_WAIT:   state_in = ST_PIV_RD;
         ST_PIV_RD:     state_in = ST_PIV_WR_LO;
         ST_PIV_WR_LO:  state_in = ST_PIV_WR_MID;
         ST_PIV_WR_MID: state_in = ST_SCAN_A;
         ST_SCAN_A: begin
            state_in = (a_ff <= {1'b0, hi_ff}) ? ST_SCAN_A_CHK : ST_SCAN_B;
         end
         ST_SCAN_A_CHK: state_in = (rd_key <= piv_key) ? ST_SCAN_A : ST_SCAN_B;
         ST_SCAN_B:     state_in = ST_SCAN_B_CHK;
         ST_SCAN_B_CHK: begin
            if (rd_key > piv_key) begin
               state_in = ST_SCAN_B;
            end else if (a_ff < {1'b0, b_ff}) begin
               state_in = ST_SWAP_A;
            end else if (a_ff == {1'b0, b_ff}) begin
               state_in = ST_SCAN_A;
            end else begin
               state_in = ST_FIN_LO;
            end
         end
         ST_SWAP_A:     state_in = ST_SWAP_B;
         ST_SWAP_B:     state_in = ST_SCAN_A;
         ST_FIN_LO:     state_in = ST_FIN_B;
         ST_FIN_B:      state_in = (sp_in == '0) ? ST_OUT : ST_POP;
         ST_OUT: begin
            if (k_ff == fill_ff - 1'b1) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = lo_ff;
      ent_wdata = dat_b_ff;
      ent_raddr = lo_ff;
      stk_we    = 1'b0;
      stk_waddr = sp_ff[IDXW-1:0];
      stk_wdata = {lo_ff, hi_ff};
      stk_raddr = sp_in[IDXW-1:0];
      case (state_ff)
         ST_IDLE: begin
            ent_we    = accept && has_room;
            ent_waddr = fill_ff[IDXW-1:0];
            ent_wdata = {req_key, req_tag};
            stk_we    = accept && req_last && (n_load > CNTW'(1));
            stk_waddr = '0;
            stk_wdata = {IDXW'(0), IDXW'(n_load - 1'b1)};
         end
         ST_POP_WAIT: ent_raddr = stk_rdata[STKW-1 -: IDXW];
         ST_PIV_RD:   ent_raddr = mid;
         ST_PIV_WR_LO: begin
            ent_we    = 1'b1;
            ent_waddr = lo_ff;
            ent_wdata = ent_rdata;
         end
         ST_PIV_WR_MID: begin
            ent_we    = 1'b1;
            ent_waddr = mid;
            ent_wdata = tmp_ff;
         end
         ST_SCAN_A:   ent_raddr = a_ff[IDXW-1:0];
         ST_SCAN_B:   ent_raddr = b_ff;
         ST_SWAP_A: begin
            ent_we    = 1'b1;
            ent_waddr = a_ff[IDXW-1:0];
            ent_wdata = dat_b_ff;
         end
         ST_SWAP_B: begin
            ent_we    = 1'b1;
            ent_waddr = b_ff;
            ent_wdata = dat_a_ff;
         end
         ST_FIN_LO: begin
            ent_we    = 1'b1;
            ent_waddr = lo_ff;
            ent_wdata = dat_b_ff;
            stk_we    = push_right;
            stk_wdata = {b_ff + 1'b1, hi_ff};
         end
         ST_FIN_B: begin
            ent_we    = 1'b1;
            ent_waddr = b_ff;
            ent_wdata = piv_ff;
            stk_we    = push_left;
            stk_wdata = {lo_ff, b_ff - 1'b1};
         end
         ST_OUT:      ent_raddr = k_ff[IDXW-1:0];
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      fill_in  = fill_ff;
      sp_in    = sp_ff;
      k_in     = k_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      tmp_in   = tmp_ff;
      piv_in   = piv_ff;
      dat_a_in = dat_a_ff;
      dat_b_in = dat_b_ff;
      pend_in  = 1'b0;
      fin_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = n_load;
               if (req_last) begin
                  k_in  = '0;
                  sp_in = (n_load > CNTW'(1)) ? CNTW'(1) : '0;
               end
            end
         end
         ST_POP: sp_in = sp_ff - 1'b1;
         ST_POP_WAIT: begin
            lo_in = stk_rdata[STKW-1 -: IDXW];
            hi_in = stk_rdata[IDXW-1:0];
         end
         ST_PIV_RD:    tmp_in = ent_rdata;
         ST_PIV_WR_LO: piv_in = ent_rdata;
         ST_PIV_WR_MID: begin
            a_in = {1'b0, lo_ff} + 1'b1;
            b_in = hi_ff;
         end
         ST_SCAN_A_CHK: begin
            if (rd_key <= piv_key) begin
               a_in = a_ff + 1'b1;
            end else begin
               dat_a_in = ent_rdata;
            end
         end
         ST_SCAN_B_CHK: begin
            if (rd_key > piv_key) begin
               b_in = b_ff - 1'b1;
            end else begin
               dat_b_in = ent_rdata;
            end
         end
         ST_FIN_LO: begin
            if (push_right) begin
               sp_in = sp_ff + 1'b1;
            end
         end
         ST_FIN_B: begin
            if (push_left) begin
               sp_in = sp_ff + 1'b1;
            end
         end
         ST_OUT: begin
            pend_in = 1'b1;
            fin_in  = (k_ff == fill_ff - 1'b1);
            k_in    = k_ff + 1'b1;
            if (k_ff == fill_ff - 1'b1) begin
               fill_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         sp_ff    <= '0;
         pend_ff  <= 1'b0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         sp_ff    <= sp_in;
         pend_ff  <= pend_in;
         fin_ff   <= fin_in;
      end
   end

   // payload: hold until overwritten, no reset needed
   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      tmp_ff   <= tmp_in;
      piv_ff   <= piv_in;
      dat_a_ff <= dat_a_in;
      dat_b_ff <= dat_b_in;
   end

endmodule

`default_nettype wire

// ----- test/key_tag_quicksort_tb.sv -----
`timescale 1ns / 1ps

module key_tag_quicksort_tb;

   import kts_pkg::*;

   localparam int DEPTH       = DEFAULT_MAX_ENTRIES;
   localparam int ITEM_TARGET = 330;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 200;

   // One sorted pair as it should leave the block.
   typedef struct {
      logic signed [KEY_W-1:0] key;
      logic signed [TAG_W-1:0] tag;
      logic                    final_res;
   } sorted_pair_type;

   // Shapes of key sequences for one set.
   typedef enum int {
      KEYS_RANDOM,
      KEYS_NARROW,
      KEYS_RISING,
      KEYS_FALLING,
      KEYS_SAME
   } key_pattern_type;

   // Mirrors the block's entry store and its middle-pivot quicksort. Each closed set
   // turns into a run of expected sorted pairs, checked in order against the strobes.
   class sorted_pair_checker;
      logic signed [KEY_W-1:0] key_mem[DEPTH];
      logic signed [TAG_W-1:0] tag_mem[DEPTH];
      int                      fill;
      sorted_pair_type         expected_pairs[$];
      int                      errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function void swap_entries(int i, int j);
         logic signed [KEY_W-1:0] k;
         logic signed [TAG_W-1:0] t;
         k          = key_mem[i];
         t          = tag_mem[i];
         key_mem[i] = key_mem[j];
         tag_mem[i] = tag_mem[j];
         key_mem[j] = k;
         tag_mem[j] = t;
      endfunction

      function void push_range(ref int lo_q[$], ref int hi_q[$], input int lo, input int hi);
         if (lo < hi) begin
            lo_q.push_back(lo);
            hi_q.push_back(hi);
         end
      endfunction

      // Store one accepted pair; on last, sort and queue the whole set.
      function void load_pair(logic signed [KEY_W-1:0] k, logic signed [TAG_W-1:0] t,
                              logic last);
         int                      lo_q[$];
         int                      hi_q[$];
         int                      lo, hi, mid, a, b;
         logic signed [KEY_W-1:0] pivot;
         sorted_pair_type         pair;
         if (fill < DEPTH) begin
            key_mem[fill] = k;
            tag_mem[fill] = t;
            fill++;
         end
         if (!last)
            return;
         push_range(lo_q, hi_q, 0, fill - 1);
         while (lo_q.size() > 0) begin
            lo    = lo_q.pop_back();
            hi    = hi_q.pop_back();
            mid   = (lo + hi) / 2;
            swap_entries(lo, mid);
            pivot = key_mem[lo];
            a     = lo + 1;
            b     = hi;
            while (a <= b) begin
               while (a <= hi && key_mem[a] <= pivot)
                  a++;
               while (b >= lo && key_mem[b] > pivot)
                  b--;
               if (a < b)
                  swap_entries(a, b);
            end
            swap_entries(lo, b);
            // right range goes on first so the left one comes off first
            push_range(lo_q, hi_q, b + 1, hi);
            push_range(lo_q, hi_q, lo, b - 1);
         end
         for (int i = 0; i < fill; i++) begin
            pair.key       = key_mem[i];
            pair.tag       = tag_mem[i];
            pair.final_res = (i == fill - 1);
            expected_pairs.push_back(pair);
         end
         fill = 0;
      endfunction

      function void check_pair(logic signed [KEY_W-1:0] k, logic signed [TAG_W-1:0] t,
                               logic f);
         sorted_pair_type exp_pair;
         if (expected_pairs.size() == 0) begin
            $display("%0t: unexpected result key=%0d tag=%h final=%b", $time, k, t, f);
            errors++;
            return;
         end
         exp_pair = expected_pairs.pop_front();
         if (exp_pair.key !== k) begin
            $display("%0t: sorted_key expected %0d actual %0d", $time, exp_pair.key, k);
            errors++;
         end
         if (exp_pair.tag !== t) begin
            $display("%0t: sorted_tag expected %h actual %h", $time, exp_pair.tag, t);
            errors++;
         end
         if (exp_pair.final_res !== f) begin
            $display("%0t: final_res expected %b actual %b", $time, exp_pair.final_res, f);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [KEY_W-1:0] req_key;
   logic signed [TAG_W-1:0] req_tag;
   logic                    req_last;
   logic                    rsp_valid;
   logic signed [KEY_W-1:0] rsp_sorted_key;
   logic signed [TAG_W-1:0] rsp_sorted_tag;
   logic                    rsp_final_res;

   sorted_pair_checker sorter = new();
   int                 items_sent;

   key_tag_quicksort uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_key        (req_key),
      .req_tag        (req_tag),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_sorted_key (rsp_sorted_key),
      .rsp_sorted_tag (rsp_sorted_tag),
      .rsp_final_res  (rsp_final_res)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample both channels at the rising edge. A transfer happens when start is high
   // and busy is low; a result is there for exactly the one cycle its strobe is high.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sorter.load_pair(req_key, req_tag, req_last);
         if (rsp_valid === 1'b1)
            sorter.check_pair(rsp_sorted_key, rsp_sorted_tag, rsp_final_res);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("key_tag_quicksort_tb: FAIL");
      $finish;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [KEY_W-1:0] make_key(key_pattern_type pattern, int idx,
                                                        logic signed [KEY_W-1:0] base);
      case (pattern)
         KEYS_NARROW:  return $signed($urandom_range(0, 8)) - 4;
         KEYS_RISING:  return base + idx;
         KEYS_FALLING: return base - idx;
         KEYS_SAME:    return base;
         default:      return $urandom;
      endcase
   endfunction

   // Present one item from a falling edge and hold it until the block takes it.
   // Leave start high when no gap follows, so back-to-back items never toggle it.
   task automatic send_item(input logic signed [KEY_W-1:0] k,
                            input logic signed [TAG_W-1:0] t,
                            input logic l, input int gap);
      start    <= 1'b1;
      req_key  <= k;
      req_tag  <= t;
      req_last <= l;
      do
         @(posedge clock);
      while (busy);
      items_sent++;
      @(negedge clock);
      if (gap > 0) begin
         // drop start and scramble the idle payload for the length of the gap
         start    <= 1'b0;
         req_key  <= $urandom;
         req_tag  <= $urandom;
         req_last <= $urandom_range(0, 1);
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      int                      set_idx;
      int                      set_size;
      int                      r;
      bit                      no_idle;
      key_pattern_type         pattern;
      logic signed [KEY_W-1:0] base;
      logic signed [KEY_W-1:0] dir_keys[7];
      logic signed [TAG_W-1:0] dir_tags[7];

      items_sent = 0;
      start      = 1'b0;
      req_key    = '0;
      req_tag    = '0;
      req_last   = 1'b0;
      reset      = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Single element: the pair comes straight back with final_res set.
      send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 0);

      // Extremes of key and tag, with repeated extreme keys.
      dir_keys = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1,
                   32'sh8000_0000, 32'sh7FFF_FFFF};
      dir_tags = '{32'shFFFF_FFFF, 32'sh0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1};
      for (int i = 0; i < 7; i++)
         send_item(dir_keys[i], dir_tags[i], i == 6, 0);

      // Equal keys: the tag order shows the exact partition steps.
      for (int i = 0; i < 4; i++)
         send_item(32'sd5, i, i == 3, (i == 1) ? 2 : 0);

      // Two elements out of order.
      send_item(32'sd1, 32'sh1234_5678, 1'b0, 0);
      send_item(32'sd0, 32'sh9ABC_DEF0, 1'b1, 3);

      // Random sets. Open with one that overflows the store, then mostly small
      // sets with an occasional near-full, full or overflowing one.
      set_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (set_idx == 0)
            set_size = DEPTH + 3;
         else if (r < 80)
            set_size = $urandom_range(1, 10);
         else if (r < 92)
            set_size = $urandom_range(11, 40);
         else
            set_size = $urandom_range(DEPTH - 4, DEPTH + 8);
         pattern = key_pattern_type'($urandom_range(KEYS_RANDOM, KEYS_SAME));
         base    = $urandom;
         no_idle = ($urandom_range(0, 99) < 30);
         for (int i = 0; i < set_size; i++)
            send_item(make_key(pattern, i, base), $urandom, i == set_size - 1,
                      no_idle ? 0 : pick_gap());
         set_idx++;
      end

      // Hold start low and let the last set drain.
      start <= 1'b0;
      while (sorter.expected_pairs.size() > 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sorter.errors == 0 && sorter.expected_pairs.size() == 0) begin
         $display("key_tag_quicksort_tb: PASS");
      end else begin
         $display("%0t: %0d errors, %0d results missing", $time, sorter.errors,
                  sorter.expected_pairs.size());
         $display("key_tag_quicksort_tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- key_tag_quicksort.f -----
rtl/core/kts_pkg.sv
rtl/core/kts_ram.sv
rtl/core/key_tag_quicksort.sv
test/key_tag_quicksort_tb.sv
